// ----- src/pdsc_pkg.sv -----
`timescale 1ns / 1ps

package pdsc_pkg;

    // Width of the class totals; the result fields show the low 16 bits.
    localparam int COUNT_WIDTH = 16;

    localparam int LIMIT_WIDTH = 16;
    localparam int TICK_WIDTH  = 16;
    localparam int FIELD_WIDTH = 16;

    localparam int CFG_COUNT       = 4;
    localparam int CFG_INDEX_WIDTH = $clog2(CFG_COUNT);

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JAM_LIMIT    = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SMALL_LIMIT  = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIDDLE_LIMIT = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LARGE_LIMIT  = CFG_INDEX_WIDTH'(3);

    localparam logic [LIMIT_WIDTH-1:0] JAM_LIMIT_RST    = LIMIT_WIDTH'(1000);
    localparam logic [LIMIT_WIDTH-1:0] SMALL_LIMIT_RST  = LIMIT_WIDTH'(100);
    localparam logic [LIMIT_WIDTH-1:0] MIDDLE_LIMIT_RST = LIMIT_WIDTH'(200);
    localparam logic [LIMIT_WIDTH-1:0] LARGE_LIMIT_RST  = LIMIT_WIDTH'(400);

    // Passages shorter than this are treated as noise
    localparam logic [TICK_WIDTH-1:0] MIN_TICKS = TICK_WIDTH'(10);

    // op codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SENSOR = 1'b1;

    typedef struct packed {
        logic [LIMIT_WIDTH-1:0] jam_limit;
        logic [LIMIT_WIDTH-1:0] small_limit;
        logic [LIMIT_WIDTH-1:0] middle_limit;
        logic [LIMIT_WIDTH-1:0] large_limit;
    } t_cfg;

    typedef struct packed {
        logic op;
        logic enter_seen;
        logic exit_seen;
    } t_item;

    typedef struct packed {
        logic                   timing_on;
        logic                   end_pending;
        logic [TICK_WIDTH-1:0]  passage_ticks;
        logic [COUNT_WIDTH-1:0] small_total;
        logic [COUNT_WIDTH-1:0] middle_total;
        logic [COUNT_WIDTH-1:0] large_total;
        logic                   jam_mark;
        logic                   alarm_mark;
        logic                   refresh_mark;
    } t_state;

endpackage

// ----- src/pdsc_in_if.sv -----
`timescale 1ns / 1ps

interface pdsc_in_if;
    logic valid;
    logic ready;
    logic op;
    logic enter_seen;
    logic exit_seen;

    modport source (output valid, output op, output enter_seen, output exit_seen,
                    input ready);
    modport sink (input valid, input op, input enter_seen, input exit_seen,
                  output ready);
endinterface

// ----- src/pdsc_out_if.sv -----
`timescale 1ns / 1ps

interface pdsc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] small_count;
    logic [15:0] middle_count;
    logic [15:0] large_count;
    logic        jam_seen;
    logic        alarm_seen;
    logic        refresh_needed;
    logic        timing_active;

    modport source (output valid, output small_count, output middle_count,
                    output large_count, output jam_seen, output alarm_seen,
                    output refresh_needed, output timing_active, input ready);
    modport sink (input valid, input small_count, input middle_count,
                  input large_count, input jam_seen, input alarm_seen,
                  input refresh_needed, input timing_active, output ready);
endinterface

// ----- src/pdsc_cfg_regs.sv -----
`timescale 1ns / 1ps

module pdsc_cfg_regs
    import pdsc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [LIMIT_WIDTH-1:0]     i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.jam_limit    <= JAM_LIMIT_RST;
            r_cfg.small_limit  <= SMALL_LIMIT_RST;
            r_cfg.middle_limit <= MIDDLE_LIMIT_RST;
            r_cfg.large_limit  <= LARGE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_JAM_LIMIT:    r_cfg.jam_limit    <= i_cfg_data;
                CFG_SMALL_LIMIT:  r_cfg.small_limit  <= i_cfg_data;
                CFG_MIDDLE_LIMIT: r_cfg.middle_limit <= i_cfg_data;
                CFG_LARGE_LIMIT:  r_cfg.large_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/pdsc_update.sv -----
`timescale 1ns / 1ps

module pdsc_update
    import pdsc_pkg::*;
(
    input  t_cfg   i_cfg,
    input  t_item  i_item,
    input  t_state i_state,
    output t_state o_state
);

    logic [TICK_WIDTH-1:0] w_ticks_inc;
    logic [TICK_WIDTH-1:0] w_t;

    assign w_ticks_inc = i_state.passage_ticks + TICK_WIDTH'(1);
    assign w_t         = i_state.passage_ticks;

    always_comb begin
        o_state = i_state;
        if (i_item.op == OP_SENSOR) begin
            if (i_item.enter_seen && !i_item.exit_seen) begin
                o_state.timing_on   = 1'b1;
                o_state.end_pending = 1'b0;
            end else if (!i_item.enter_seen && i_item.exit_seen) begin
                o_state.timing_on   = 1'b0;
                o_state.end_pending = 1'b1;
            end
        end else if (i_state.timing_on) begin
            o_state.passage_ticks = w_ticks_inc;
            if (w_ticks_inc > i_cfg.jam_limit) begin
                // jam: stop timing, raise flags
                o_state.jam_mark      = 1'b1;
                o_state.alarm_mark    = 1'b1;
                o_state.refresh_mark  = 1'b1;
                o_state.passage_ticks = '0;
                o_state.timing_on     = 1'b0;
                o_state.end_pending   = 1'b0;
            end
        end else if (i_state.end_pending) begin
            o_state.timing_on   = 1'b0;
            o_state.end_pending = 1'b0;
            if (w_t < MIN_TICKS) begin
                o_state.passage_ticks = '0;
            end else begin
                o_state.refresh_mark = 1'b1;
                // first test that holds wins; a count on a limit matches none
                if (w_t > i_cfg.large_limit) begin
                    o_state.alarm_mark    = 1'b1;
                    o_state.passage_ticks = '0;
                end else if (w_t > i_cfg.small_limit && w_t < i_cfg.middle_limit) begin
                    o_state.middle_total  = i_state.middle_total + COUNT_WIDTH'(1);
                    o_state.passage_ticks = '0;
                end else if (w_t > i_cfg.middle_limit && w_t < i_cfg.large_limit) begin
                    o_state.large_total   = i_state.large_total + COUNT_WIDTH'(1);
                    o_state.passage_ticks = '0;
                end else if (w_t < i_cfg.small_limit) begin
                    o_state.small_total   = i_state.small_total + COUNT_WIDTH'(1);
                    o_state.passage_ticks = '0;
                end
            end
        end
    end

endmodule

// ----- src/pulse_duration_size_classifier_core.sv -----
`timescale 1ns / 1ps
// Path: an accepted input transaction waits in the input register, then moves
//   to the result register when the result stage can advance.
// Throughput: one transaction per cycle; the two-stage pipeline stalls only
//   when the result register is full and not taken.
// Reset: synchronous, active low; clears pipeline valids, all counters and
//   sticky flags, and loads the limit registers with their defaults.

module pulse_duration_size_classifier_core
    import pdsc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    pdsc_in_if.sink                    i_item,
    pdsc_out_if.source                 o_result,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [LIMIT_WIDTH-1:0]     i_cfg_data
);

    t_cfg   w_cfg;
    t_item  r_item;
    logic   r_in_valid;
    logic   r_out_valid;
    t_state r_state;
    t_state n_state;
    logic   w_advance;
    logic   w_in_ready;

    // Result fields, registered
    logic [FIELD_WIDTH-1:0] r_small_count;
    logic [FIELD_WIDTH-1:0] r_middle_count;
    logic [FIELD_WIDTH-1:0] r_large_count;
    logic                   r_jam_seen;
    logic                   r_alarm_seen;
    logic                   r_refresh_needed;
    logic                   r_timing_active;

    pdsc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Next state for the item in the input register
    pdsc_update u_update (
        .i_cfg   (w_cfg),
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state)
    );

    // Result stage moves when it is empty or being drained
    assign w_advance  = !r_out_valid || o_result.ready;
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_item.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    // state commits when the transaction leaves the input stage
                    r_state <= n_state;
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_item.valid) begin
            r_item.op         <= i_item.op;
            r_item.enter_seen <= i_item.enter_seen;
            r_item.exit_seen  <= i_item.exit_seen;
        end
        if (w_advance && r_in_valid) begin
            r_small_count    <= FIELD_WIDTH'(n_state.small_total);
            r_middle_count   <= FIELD_WIDTH'(n_state.middle_total);
            r_large_count    <= FIELD_WIDTH'(n_state.large_total);
            r_jam_seen       <= n_state.jam_mark;
            r_alarm_seen     <= n_state.alarm_mark;
            r_refresh_needed <= n_state.refresh_mark;
            r_timing_active  <= n_state.timing_on;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.small_count    = r_small_count;
    assign o_result.middle_count   = r_middle_count;
    assign o_result.large_count    = r_large_count;
    assign o_result.jam_seen       = r_jam_seen;
    assign o_result.alarm_seen     = r_alarm_seen;
    assign o_result.refresh_needed = r_refresh_needed;
    assign o_result.timing_active  = r_timing_active;

endmodule

// ----- src/pdsc_checker.sv -----
`timescale 1ns / 1ps

module pdsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_small_count,
    input logic        i_jam_seen,
    input logic        i_alarm_seen,
    input logic        i_refresh_needed
);

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_small_count)))
        else $error("stalled result changed");

    // A jam always raises the alarm
    a_jam_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_jam_seen) |-> i_alarm_seen)
        else $error("jam without alarm");

    // The sticky refresh flag never drops between back-to-back results
    a_refresh_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_refresh_needed) |=> (!i_out_valid || i_refresh_needed))
        else $error("refresh flag dropped");

endmodule

bind pulse_duration_size_classifier_core pdsc_checker u_pdsc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_small_count    (o_result.small_count),
    .i_jam_seen       (o_result.jam_seen),
    .i_alarm_seen     (o_result.alarm_seen),
    .i_refresh_needed (o_result.refresh_needed)
);
